[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in a cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/hus_pkg.sv]
// Shared types, codes and character constants of the URL splitter.
package hus_pkg;

  localparam logic [1:0] KIND_HOST    = 2'd0;
  localparam logic [1:0] KIND_PATH    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] DEFAULT_PORT_RST = 16'd80;
  localparam logic [2:0]  PREFIX_LAST      = 3'd6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data;
    logic signed [31:0] port;
    logic               ok;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0]                    count;
    result_t [MAX_RESULTS-1:0]     res;
  } push_t;

  // Expected lower-case character of the scheme at each position.
  function automatic logic [7:0] scheme_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0: ch = 8'h68;
      3'd1: ch = 8'h74;
      3'd2: ch = 8'h74;
      3'd3: ch = 8'h70;
      3'd4: ch = CH_COLON;
      3'd5: ch = CH_SLASH;
      3'd6: ch = CH_SLASH;
      default: ch = 8'hFF;
    endcase
    return ch;
  endfunction

endpackage

[rtl/core/http_url_splitter.sv]
// Top level of the URL splitter: input handshake, parser and result bank.
// Each result is written into the registered result bank when its url byte is accepted.
// Throughput: one byte per cycle while each byte yields one result and out_stall is low; a byte with
// several results (end of url) holds input until the result bank drains to one.
// Output rate is one result per cycle while out_stall is low, set by the single head slot of the bank.
// Reset (rst_n low, synchronous): parse state cleared, bank emptied, port 80.
`include "assert_macros.svh"

module http_url_splitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_url_byte,
  input  logic               in_url_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_item_kind,
  output logic [7:0]         out_out_byte,
  output logic signed [31:0] out_port_value,
  output logic               out_scheme_ok,
  output logic               out_run_last,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  logic                        in_acc;
  logic                        out_acc;
  hus_pkg::push_t              push;
  hus_pkg::result_t            head;
  logic [hus_pkg::LEVEL_W-1:0] level;

  // Room for a full three-result burst after at most one waiting result
  assign in_stall = level > hus_pkg::LEVEL_W'(1);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = level != '0;
  assign out_acc  = out_valid && !out_stall;

  hus_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .url_byte    (in_url_byte),
    .url_end     (in_url_end),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push)
  );

  hus_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_acc),
    .head  (head),
    .level (level)
  );

  assign out_item_kind  = head.kind;
  assign out_out_byte   = head.data;
  assign out_port_value = head.port;
  assign out_scheme_ok  = head.ok;
  assign out_run_last   = head.last;

  `ASSERT_ALWAYS(a_level_bound, clk, rst_n, level <= hus_pkg::LEVEL_W'(hus_pkg::QUEUE_DEPTH), "result bank overflow")
  `ASSERT_ALWAYS(a_last_is_summary, clk, rst_n, !out_valid || (out_run_last == (out_item_kind == hus_pkg::KIND_SUMMARY)), "run_last not on summary")
  `ASSERT_ALWAYS(a_end_pushes, clk, rst_n, !(in_acc && in_url_end) || push.count != 2'd0, "url end without summary")
  `ASSERT_NEXT(a_level_track, clk, rst_n, 1'b1, level == $past(level) - hus_pkg::LEVEL_W'($past(out_acc)) + hus_pkg::LEVEL_W'($past(push.count)), "bank level mismatch")

endmodule

[rtl/core/hus_parser.sv]
// Parse state machine: one url byte per step, emits up to three results.
module hus_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        url_byte,
  input  logic              url_end,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  output hus_pkg::push_t    push
);

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_HOST,
    PH_GAP,
    PH_PORT_WS,
    PH_PORT_NUM,
    PH_PATH,
    PH_HALT
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [2:0]         prefix_pos_r, prefix_pos_nxt;
  logic               prefix_failed_r, prefix_failed_nxt;
  logic signed [31:0] port_accum_r, port_accum_nxt;
  logic               port_negative_r, port_negative_nxt;
  logic               port_given_r, port_given_nxt;
  logic               path_seen_r, path_seen_nxt;
  logic [15:0]        default_port_r;

  always_comb begin
    phase_t             ph;
    logic               failed;
    logic [2:0]         pos;
    logic signed [31:0] acc;
    logic               neg;
    logic               given;
    logic               path;
    logic [7:0]         c;
    logic [7:0]         low;
    logic               is_ws;
    logic               is_digit;
    logic [31:0]        times10;
    logic [31:0]        digit;
    logic               body_en;
    hus_pkg::result_t   body;
    hus_pkg::result_t   slash;
    hus_pkg::result_t   summ;
    logic               ok;
    logic [1:0]         n;

    c        = url_byte;
    ph       = phase_r;
    failed   = prefix_failed_r;
    pos      = prefix_pos_r;
    acc      = port_accum_r;
    neg      = port_negative_r;
    given    = port_given_r;
    path     = path_seen_r;
    low      = (c >= hus_pkg::CH_UPPER_A && c <= hus_pkg::CH_UPPER_Z) ? (c | 8'h20) : c;
    is_ws    = (c == hus_pkg::CH_SPACE) || (c >= hus_pkg::CH_TAB && c <= hus_pkg::CH_CR);
    is_digit = (c >= hus_pkg::CH_ZERO) && (c <= hus_pkg::CH_NINE);
    times10  = (port_accum_r <<< 3) + (port_accum_r <<< 1);
    digit    = {28'd0, c[3:0]};
    body_en  = 1'b0;
    body     = '{kind: hus_pkg::KIND_HOST, data: c, port: '0, ok: 1'b1, last: 1'b0};

    // A zero byte ends the url text
    if (c == hus_pkg::CH_NUL && ph != PH_HALT) begin
      if (ph == PH_PREFIX) failed = 1'b1;
      ph = PH_HALT;
    end

    unique case (ph)
      PH_PREFIX: begin
        if (low != hus_pkg::scheme_char(pos)) begin
          failed = 1'b1;
          ph     = PH_HALT;
        end else if (pos == hus_pkg::PREFIX_LAST) begin
          ph = PH_HOST;
        end else begin
          pos = pos + 3'd1;
        end
      end
      PH_HOST: begin
        if (c == hus_pkg::CH_COLON) begin
          given = 1'b1;
          ph    = PH_PORT_WS;
        end else if (c == hus_pkg::CH_SLASH) begin
          path      = 1'b1;
          ph        = PH_PATH;
          body_en   = 1'b1;
          body.kind = hus_pkg::KIND_PATH;
        end else if (c == hus_pkg::CH_SPACE || c == hus_pkg::CH_CR || c == hus_pkg::CH_LF) begin
          ph = PH_GAP;
        end else begin
          body_en = 1'b1;
        end
      end
      PH_GAP, PH_PORT_WS, PH_PORT_NUM: begin
        if (c == hus_pkg::CH_SLASH) begin
          path      = 1'b1;
          ph        = PH_PATH;
          body_en   = 1'b1;
          body.kind = hus_pkg::KIND_PATH;
        end else if (ph == PH_PORT_WS && is_ws) begin
          ph = PH_PORT_WS;
        end else if (ph == PH_PORT_WS && (c == hus_pkg::CH_PLUS || c == hus_pkg::CH_MINUS)) begin
          neg = (c == hus_pkg::CH_MINUS);
          ph  = PH_PORT_NUM;
        end else if (ph != PH_GAP && is_digit) begin
          // keep the signed value: -(10a + d) == 10(-a) - d modulo 2^32
          acc = neg ? $signed(times10 - digit) : $signed(times10 + digit);
          ph  = PH_PORT_NUM;
        end else begin
          ph = PH_GAP;
        end
      end
      PH_PATH: begin
        body_en   = 1'b1;
        body.kind = hus_pkg::KIND_PATH;
      end
      PH_HALT: begin
        ph = PH_HALT;
      end
      default: begin
        ph = PH_HALT;
      end
    endcase

    ok    = !failed && ph != PH_PREFIX;
    slash = '{kind: hus_pkg::KIND_PATH, data: hus_pkg::CH_SLASH, port: '0, ok: 1'b1,
              last: 1'b0};
    summ  = '{kind: hus_pkg::KIND_SUMMARY, data: 8'd0, port: '0, ok: ok, last: 1'b1};
    if (ok) summ.port = given ? acc : $signed({16'd0, default_port_r});

    push.res = '{default: summ};
    n        = 2'd0;
    if (body_en) begin
      push.res[n] = body;
      n           = n + 2'd1;
    end
    if (url_end) begin
      if (ok && !path) begin
        push.res[n] = slash;
        n           = n + 2'd1;
      end
      push.res[n] = summ;
      n           = n + 2'd1;
    end
    push.count = step ? n : 2'd0;

    phase_nxt         = ph;
    prefix_pos_nxt    = pos;
    prefix_failed_nxt = failed;
    port_accum_nxt    = acc;
    port_negative_nxt = neg;
    port_given_nxt    = given;
    path_seen_nxt     = path;
    // Clear the run after the summary
    if (url_end) begin
      phase_nxt         = PH_PREFIX;
      prefix_pos_nxt    = '0;
      prefix_failed_nxt = 1'b0;
      port_accum_nxt    = '0;
      port_negative_nxt = 1'b0;
      port_given_nxt    = 1'b0;
      path_seen_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_PREFIX;
      prefix_pos_r    <= '0;
      prefix_failed_r <= 1'b0;
      port_accum_r    <= '0;
      port_negative_r <= 1'b0;
      port_given_r    <= 1'b0;
      path_seen_r     <= 1'b0;
      default_port_r  <= hus_pkg::DEFAULT_PORT_RST;
    end else begin
      if (step) begin
        phase_r         <= phase_nxt;
        prefix_pos_r    <= prefix_pos_nxt;
        prefix_failed_r <= prefix_failed_nxt;
        port_accum_r    <= port_accum_nxt;
        port_negative_r <= port_negative_nxt;
        port_given_r    <= port_given_nxt;
        path_seen_r     <= path_seen_nxt;
      end
      if (cfg_wr_en) default_port_r <= cfg_wr_data;
    end
  end

endmodule

[rtl/core/hus_outq.sv]
// Result register bank: takes up to three results, hands out one per cycle while pop is high.
module hus_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hus_pkg::push_t               push,
  input  logic                         pop,
  output hus_pkg::result_t             head,
  output logic [hus_pkg::LEVEL_W-1:0]  level
);

  hus_pkg::result_t [hus_pkg::QUEUE_DEPTH-1:0] slot_r, slot_nxt;
  logic [hus_pkg::LEVEL_W-1:0]                  level_r, level_nxt;

  always_comb begin
    logic [hus_pkg::LEVEL_W-1:0] base;
    logic [hus_pkg::LEVEL_W-1:0] k;
    base     = level_r - {{(hus_pkg::LEVEL_W-1){1'b0}}, pop};
    slot_nxt = slot_r;
    for (int i = 0; i < hus_pkg::QUEUE_DEPTH; i++) begin
      k = hus_pkg::LEVEL_W'(i) - base;
      if (hus_pkg::LEVEL_W'(i) < base) begin
        // shift down behind the item leaving at the head
        if (pop && i < hus_pkg::QUEUE_DEPTH - 1) slot_nxt[i] = slot_r[i+1];
      end else if (k < hus_pkg::LEVEL_W'(push.count)) begin
        slot_nxt[i] = push.res[k[1:0]];
      end
    end
    level_nxt = base + hus_pkg::LEVEL_W'(push.count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign head  = slot_r[0];
  assign level = level_r;

endmodule
